// ----- hw/rtl/xdec_pkg.sv -----
// Package for the 16-bit x86 instruction decoder.
// Holds phase, form and mnemonic codes and the opcode classification functions.
// No dependencies.
package xdec_pkg;

    localparam int NUM_REGISTERS_DEF = 8;

    localparam logic CFG_EXEC_EN = 1'b0;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_MODRM,
        PH_DISP_LO,
        PH_DISP_HI,
        PH_IMM_LO,
        PH_IMM_HI
    } phase_t;

    typedef enum logic [2:0] {
        FORM_RM_REG,
        FORM_IMM_RM,
        FORM_IMM_REG,
        FORM_MEM_ACC,
        FORM_ACC_MEM,
        FORM_IMM_ACC,
        FORM_JNZ
    } form_t;

    typedef enum logic [1:0] {
        MN_MOV,
        MN_ADD,
        MN_SUB,
        MN_CMP
    } mnem_t;

    typedef struct packed {
        logic  hit;
        form_t form;
        mnem_t mnem;
    } op_class_t;

    function automatic op_class_t classify(input logic [7:0] op);
        op_class_t c;
        c.hit  = 1'b1;
        c.form = FORM_RM_REG;
        c.mnem = MN_MOV;
        priority if (op[7:2] == 6'b100010) begin
            c.form = FORM_RM_REG;
        end else if (op[7:1] == 7'b1100011) begin
            c.form = FORM_IMM_RM;
        end else if (op[7:4] == 4'b1011) begin
            c.form = FORM_IMM_REG;
        end else if (op[7:1] == 7'b1010000) begin
            c.form = FORM_MEM_ACC;
        end else if (op[7:1] == 7'b1010001) begin
            c.form = FORM_ACC_MEM;
        end else if (op[7:2] == 6'b100000) begin
            c.form = FORM_IMM_RM;
        end else if (op[7:2] == 6'b000000) begin
            c.form = FORM_RM_REG;
            c.mnem = MN_ADD;
        end else if (op[7:1] == 7'b0000010) begin
            c.form = FORM_IMM_ACC;
            c.mnem = MN_ADD;
        end else if (op[7:2] == 6'b001010) begin
            c.form = FORM_RM_REG;
            c.mnem = MN_SUB;
        end else if (op[7:1] == 7'b0010110) begin
            c.form = FORM_IMM_ACC;
            c.mnem = MN_SUB;
        end else if (op[7:2] == 6'b001110) begin
            c.form = FORM_RM_REG;
            c.mnem = MN_CMP;
        end else if (op[7:1] == 7'b0011110) begin
            c.form = FORM_IMM_ACC;
            c.mnem = MN_CMP;
        end else if (op == 8'b01110101) begin
            c.form = FORM_JNZ;
        end else begin
            c.hit = 1'b0;
        end
        return c;
    endfunction

    function automatic logic [1:0] disp_bytes(input form_t f, input logic [7:0] modrm);
        logic [1:0] n;
        n = 2'd0;
        if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
            unique case (modrm[7:6])
                2'd0:    n = (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
                2'd1:    n = 2'd1;
                2'd2:    n = 2'd2;
                default: n = 2'd0;
            endcase
        end else if (f == FORM_MEM_ACC || f == FORM_ACC_MEM) begin
            n = 2'd2;
        end else if (f == FORM_JNZ) begin
            n = 2'd1;
        end
        return n;
    endfunction

    function automatic logic [1:0] imm_bytes(input form_t f, input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (f == FORM_IMM_RM) begin
            if (op[7:2] == 6'b100000) begin
                n = (op[0] && !op[1]) ? 2'd2 : 2'd1;
            end else begin
                n = op[0] ? 2'd2 : 2'd1;
            end
        end else if (f == FORM_IMM_REG) begin
            n = op[3] ? 2'd2 : 2'd1;
        end else if (f == FORM_IMM_ACC) begin
            n = op[0] ? 2'd2 : 2'd1;
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/xdec_regfile.sv -----
// Register file of the decoder: synchronous memory, one read and one write port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on xdec_pkg.
module xdec_regfile
    import xdec_pkg::*;
#(
    parameter int NUM_REGISTERS = NUM_REGISTERS_DEF,
    localparam int IDX_W = $clog2(NUM_REGISTERS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [15:0]      rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [15:0]      wr_data
);

    logic [15:0]              mem [NUM_REGISTERS];
    logic [NUM_REGISTERS-1:0] valid_reg;
    logic [15:0]              rdata_reg;
    logic                     rvalid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : 16'h0000;

endmodule

// ----- hw/rtl/x86_16_instruction_decoder.sv -----
// Top level of the 16-bit x86 instruction decoder: byte-serial decode and result register.
// Depends on xdec_pkg and xdec_regfile.
//
//  channel  | dir | handshake              | payload
//  s_       | in  | s_valid / s_ready      | s_code_byte
//  m_       | out | m_valid / m_ready      | m_mnemonic .. m_length
//  apb      | in  | psel, penable, pready  | paddr, pwdata, prdata
//
// One code byte per cycle when s_ready is high; result is registered with the last byte.
// Register file is read when the opcode byte is taken and written with the last byte.
// s_ready drops only when the byte would complete an instruction while the
// result register is full and not being taken.
// Synchronous active-low reset clears phase, result valid, execute enable and
// register file valid bits.
module x86_16_instruction_decoder
    import xdec_pkg::*;
#(
    parameter int NUM_REGISTERS = NUM_REGISTERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_code_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_mnemonic,
    output logic [2:0]         m_form,
    output logic               m_to_register,
    output logic               m_wide,
    output logic [1:0]         m_mode,
    output logic [2:0]         m_reg_field,
    output logic [2:0]         m_rm_field,
    output logic signed [15:0] m_displacement,
    output logic [15:0]        m_immediate,
    output logic [15:0]        m_old_value,
    output logic [15:0]        m_new_value,
    output logic [2:0]         m_length
);

    localparam int IDX_W = $clog2(NUM_REGISTERS);

    logic        exec_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    logic [2:0]  count_reg, count_next;

    logic        m_valid_reg;
    mnem_t       mnem_reg;
    form_t       form_reg;
    logic        to_reg_reg;
    logic        wide_reg;
    logic [1:0]  mode_reg;
    logic [2:0]  regf_reg;
    logic [2:0]  rmf_reg;
    logic [15:0] disp_out_reg;
    logic [15:0] imm_out_reg;
    logic [15:0] old_reg;
    logic [15:0] new_reg;
    logic [2:0]  len_reg;

    op_class_t   cls_in, cls_n;
    logic [1:0]  db, ib;
    logic        finish_c, emit_c, accept;
    mnem_t       mnem_c;
    logic        to_reg_c, wide_c;
    logic [1:0]  mode_c;
    logic [2:0]  regf_c, rmf_c;
    logic [15:0] disp_c, imm_c;
    logic        wr_c;
    logic [15:0] rf_rdata;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_EXEC_EN) ? {31'b0, exec_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_EXEC_EN) begin
            exec_reg <= pwdata[0];
        end
    end

    // byte capture and next phase
    assign cls_in = classify(s_code_byte);

    always_comb begin
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        disp_next   = disp_reg;
        imm_next    = imm_reg;
        count_next  = count_reg + 3'd1;
        unique case (phase_reg)
            PH_OPCODE: begin
                if (cls_in.hit) begin
                    opcode_next = s_code_byte;
                    modrm_next  = 8'h00;
                    disp_next   = 16'h0000;
                    imm_next    = 16'h0000;
                end
                count_next = 3'd1;
            end
            PH_MODRM:   modrm_next = s_code_byte;
            PH_DISP_LO: disp_next  = {8'h00, s_code_byte};
            PH_DISP_HI: disp_next  = {s_code_byte, disp_reg[7:0]};
            PH_IMM_LO:  imm_next   = {8'h00, s_code_byte};
            PH_IMM_HI:  imm_next   = {s_code_byte, imm_reg[7:0]};
            default:    count_next = count_reg;
        endcase

        cls_n = classify(opcode_next);
        db    = disp_bytes(cls_n.form, modrm_next);
        ib    = imm_bytes(cls_n.form, opcode_next);

        finish_c   = 1'b0;
        phase_next = PH_OPCODE;
        if (phase_reg == PH_OPCODE && !cls_in.hit) begin
            phase_next = PH_OPCODE;
        end else begin
            priority if (phase_reg < PH_MODRM
                         && (cls_n.form == FORM_RM_REG || cls_n.form == FORM_IMM_RM)) begin
                phase_next = PH_MODRM;
            end else if (phase_reg < PH_DISP_LO && db != 2'd0) begin
                phase_next = PH_DISP_LO;
            end else if (phase_reg < PH_DISP_HI && db == 2'd2) begin
                phase_next = PH_DISP_HI;
            end else if (phase_reg < PH_IMM_LO && ib != 2'd0) begin
                phase_next = PH_IMM_LO;
            end else if (phase_reg < PH_IMM_HI && ib == 2'd2) begin
                phase_next = PH_IMM_HI;
            end else begin
                finish_c = 1'b1;
            end
        end
    end

    // result fields of the instruction completed by this byte
    always_comb begin
        mnem_c   = cls_n.mnem;
        to_reg_c = 1'b0;
        wide_c   = opcode_next[0];
        mode_c   = 2'd0;
        regf_c   = 3'd0;
        rmf_c    = 3'd0;
        emit_c   = finish_c;
        wr_c     = 1'b0;
        disp_c   = (db == 2'd1) ? {{8{disp_next[7]}}, disp_next[7:0]} : disp_next;
        imm_c    = imm_next;
        if (ib == 2'd1) begin
            imm_c = (opcode_next[7:2] == 6'b100000 && opcode_next[1:0] == 2'b11)
                    ? {{8{imm_next[7]}}, imm_next[7:0]} : {8'h00, imm_next[7:0]};
        end
        if (cls_n.form == FORM_RM_REG || cls_n.form == FORM_IMM_RM) begin
            mode_c = modrm_next[7:6];
            regf_c = modrm_next[5:3];
            rmf_c  = modrm_next[2:0];
        end
        if (cls_n.form == FORM_RM_REG) begin
            to_reg_c = opcode_next[1];
        end
        if (cls_n.form == FORM_IMM_RM && opcode_next[7:2] == 6'b100000) begin
            unique case (modrm_next[5:3])
                3'd0:    mnem_c = MN_ADD;
                3'd5:    mnem_c = MN_SUB;
                3'd7:    mnem_c = MN_CMP;
                default: emit_c = 1'b0;
            endcase
        end
        if (cls_n.form == FORM_IMM_REG) begin
            to_reg_c = 1'b1;
            wide_c   = opcode_next[3];
            regf_c   = opcode_next[2:0];
            wr_c     = finish_c && opcode_next[3] && exec_reg;
        end
        if (cls_n.form == FORM_MEM_ACC || cls_n.form == FORM_IMM_ACC) begin
            to_reg_c = 1'b1;
        end
        if (cls_n.form == FORM_JNZ) begin
            wide_c = 1'b0;
        end
    end

    assign s_ready = !m_valid_reg || m_ready || !emit_c;
    assign accept  = s_valid && s_ready;

    xdec_regfile #(
        .NUM_REGISTERS(NUM_REGISTERS)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept && phase_reg == PH_OPCODE && cls_in.hit),
        .rd_addr (IDX_W'(s_code_byte[2:0])),
        .rd_data (rf_rdata),
        .wr_en   (accept && wr_c),
        .wr_addr (IDX_W'(opcode_next[2:0])),
        .wr_data (imm_c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPCODE;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            disp_reg   <= disp_next;
            imm_reg    <= imm_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit_c) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit_c) begin
            mnem_reg     <= mnem_c;
            form_reg     <= cls_n.form;
            to_reg_reg   <= to_reg_c;
            wide_reg     <= wide_c;
            mode_reg     <= mode_c;
            regf_reg     <= regf_c;
            rmf_reg      <= rmf_c;
            disp_out_reg <= disp_c;
            imm_out_reg  <= imm_c;
            old_reg      <= wr_c ? rf_rdata : 16'h0000;
            new_reg      <= wr_c ? imm_c : 16'h0000;
            len_reg      <= count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mnemonic     = mnem_reg;
    assign m_form         = form_reg;
    assign m_to_register  = to_reg_reg;
    assign m_wide         = wide_reg;
    assign m_mode         = mode_reg;
    assign m_reg_field    = regf_reg;
    assign m_rm_field     = rmf_reg;
    assign m_displacement = disp_out_reg;
    assign m_immediate    = imm_out_reg;
    assign m_old_value    = old_reg;
    assign m_new_value    = new_reg;
    assign m_length       = len_reg;

    a_ready_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a pending result");

    a_values_only_imm_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_form != FORM_IMM_REG) |-> (m_old_value == 16'h0000
                                                  && m_new_value == 16'h0000))
        else $error("register values reported for a non-executing form");

    a_new_is_imm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_new_value != 16'h0000) |-> (m_new_value == m_immediate && m_wide))
        else $error("executed mov value differs from immediate");

    a_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_length >= 3'd2 && m_length <= 3'd6))
        else $error("instruction length out of range");

endmodule

// ----- test/xdec_result_checker.sv -----
// Checker for the 16-bit x86 instruction decoder: follows the code byte stream and the
// execute_enable register, predicts each decoded instruction and compares the result port.
// Depends on xdec_pkg for form, mnemonic and phase codes.
module xdec_result_checker
    import xdec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_code_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_mnemonic,
    input  logic [2:0]         m_form,
    input  logic               m_to_register,
    input  logic               m_wide,
    input  logic [1:0]         m_mode,
    input  logic [2:0]         m_reg_field,
    input  logic [2:0]         m_rm_field,
    input  logic signed [15:0] m_displacement,
    input  logic [15:0]        m_immediate,
    input  logic [15:0]        m_old_value,
    input  logic [15:0]        m_new_value,
    input  logic [2:0]         m_length,
    output int                 failures,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] EXEC_EN_ADDR = {CFG_EXEC_EN, 2'b00};
    localparam logic [5:0] GROUP_IMM    = 6'b100000;
    localparam logic [2:0] EXT_ADD      = 3'd0;
    localparam logic [2:0] EXT_SUB      = 3'd5;
    localparam logic [2:0] EXT_CMP      = 3'd7;

    typedef struct packed {
        mnem_t              mnemonic;
        form_t              form;
        logic               to_register;
        logic               wide;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [15:0]        old_value;
        logic [15:0]        new_value;
        logic [2:0]         length;
    } decoded_insn_t;

    decoded_insn_t decoded_due[$];
    decoded_insn_t want;
    int            fail_count = 0;

    phase_t      fetch_phase;
    logic [7:0]  opcode_r;
    logic [7:0]  modrm_r;
    logic [15:0] disp_r;
    logic [15:0] data_r;
    logic [2:0]  count_r;
    logic [15:0] gpr [8];
    logic        exec_en;

    function automatic logic lookup_opcode(input logic [7:0] op, output form_t f,
                                           output mnem_t mn);
        f  = FORM_RM_REG;
        mn = MN_MOV;
        unique casez (op)
            8'b1000_10??: f = FORM_RM_REG;
            8'b1100_011?: f = FORM_IMM_RM;
            8'b1011_????: f = FORM_IMM_REG;
            8'b1010_000?: f = FORM_MEM_ACC;
            8'b1010_001?: f = FORM_ACC_MEM;
            8'b1000_00??: f = FORM_IMM_RM;
            8'b0000_00??: begin f = FORM_RM_REG;  mn = MN_ADD; end
            8'b0000_010?: begin f = FORM_IMM_ACC; mn = MN_ADD; end
            8'b0010_10??: begin f = FORM_RM_REG;  mn = MN_SUB; end
            8'b0010_110?: begin f = FORM_IMM_ACC; mn = MN_SUB; end
            8'b0011_10??: begin f = FORM_RM_REG;  mn = MN_CMP; end
            8'b0011_110?: begin f = FORM_IMM_ACC; mn = MN_CMP; end
            8'b0111_0101: f = FORM_JNZ;
            default:      return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic int disp_count(input form_t f, input logic [7:0] modrm);
        if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
            unique case (modrm[7:6])
                2'd0:    return (modrm[2:0] == 3'd6) ? 2 : 0;
                2'd1:    return 1;
                2'd2:    return 2;
                default: return 0;
            endcase
        end
        if (f == FORM_MEM_ACC || f == FORM_ACC_MEM) return 2;
        if (f == FORM_JNZ) return 1;
        return 0;
    endfunction

    function automatic int data_count(input form_t f, input logic [7:0] op);
        unique case (f)
            FORM_IMM_RM: begin
                if (op[7:2] == GROUP_IMM) return (op[1:0] == 2'b01) ? 2 : 1;
                return op[0] ? 2 : 1;
            end
            FORM_IMM_REG: return op[3] ? 2 : 1;
            FORM_IMM_ACC: return op[0] ? 2 : 1;
            default:      return 0;
        endcase
    endfunction

    task automatic take_code_byte(input logic [7:0] b);
        form_t         f;
        mnem_t         mn;
        decoded_insn_t r;
        logic          wanted;
        logic          emit;
        int            q;
        int            nd;
        int            ni;
        if (fetch_phase == PH_OPCODE) begin
            if (!lookup_opcode(b, f, mn)) return;
            opcode_r = b;
            modrm_r  = '0;
            disp_r   = '0;
            data_r   = '0;
            count_r  = 3'd1;
        end else begin
            count_r = count_r + 3'd1;
            unique case (fetch_phase)
                PH_MODRM:   modrm_r = b;
                PH_DISP_LO: disp_r = {8'h00, b};
                PH_DISP_HI: disp_r[15:8] = b;
                PH_IMM_LO:  data_r = {8'h00, b};
                default:    data_r[15:8] = b;
            endcase
        end
        void'(lookup_opcode(opcode_r, f, mn));
        nd = disp_count(f, modrm_r);
        ni = data_count(f, opcode_r);
        for (q = int'(fetch_phase) + 1; q <= int'(PH_IMM_HI); q++) begin
            unique case (phase_t'(q))
                PH_MODRM:   wanted = (f == FORM_RM_REG || f == FORM_IMM_RM);
                PH_DISP_LO: wanted = (nd >= 1);
                PH_DISP_HI: wanted = (nd == 2);
                PH_IMM_LO:  wanted = (ni >= 1);
                default:    wanted = (ni == 2);
            endcase
            if (wanted) begin
                fetch_phase = phase_t'(q);
                return;
            end
        end
        fetch_phase = PH_OPCODE;

        // last byte of the instruction
        emit           = 1'b1;
        r              = '0;
        r.mnemonic     = mn;
        r.form         = f;
        r.wide         = opcode_r[0];
        r.length       = count_r;
        r.displacement = disp_r;
        if (nd == 1) r.displacement = {{8{disp_r[7]}}, disp_r[7:0]};
        r.immediate = data_r;
        if (ni == 1) begin
            if (opcode_r[7:2] == GROUP_IMM && opcode_r[1:0] == 2'b11 && data_r[7])
                r.immediate = {8'hFF, data_r[7:0]};
            else
                r.immediate = {8'h00, data_r[7:0]};
        end
        if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
            r.mode      = modrm_r[7:6];
            r.reg_field = modrm_r[5:3];
            r.rm_field  = modrm_r[2:0];
        end
        if (f == FORM_RM_REG) r.to_register = opcode_r[1];
        if (f == FORM_IMM_RM && opcode_r[7:2] == GROUP_IMM) begin
            unique case (modrm_r[5:3])
                EXT_ADD: r.mnemonic = MN_ADD;
                EXT_SUB: r.mnemonic = MN_SUB;
                EXT_CMP: r.mnemonic = MN_CMP;
                default: emit = 1'b0;
            endcase
        end
        if (f == FORM_IMM_REG) begin
            r.to_register = 1'b1;
            r.wide        = opcode_r[3];
            r.reg_field   = opcode_r[2:0];
            if (r.wide && exec_en) begin
                r.old_value         = gpr[opcode_r[2:0]];
                gpr[opcode_r[2:0]]  = r.immediate;
                r.new_value         = r.immediate;
            end
        end
        if (f == FORM_MEM_ACC || f == FORM_IMM_ACC) r.to_register = 1'b1;
        if (f == FORM_JNZ) r.wide = 1'b0;
        if (emit) decoded_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %h, got %h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            decoded_due.delete();
            fetch_phase = PH_OPCODE;
            opcode_r    = '0;
            modrm_r     = '0;
            disp_r      = '0;
            data_r      = '0;
            count_r     = '0;
            exec_en     = 1'b0;
            foreach (gpr[i]) gpr[i] = '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == EXEC_EN_ADDR)
                exec_en = pwdata[0];
            if (m_valid && m_ready) begin
                if (decoded_due.size() == 0) begin
                    $error("result transaction with no instruction pending");
                    fail_count++;
                end else begin
                    want = decoded_due.pop_front();
                    check_field("mnemonic", 16'(want.mnemonic), 16'(m_mnemonic));
                    check_field("form", 16'(want.form), 16'(m_form));
                    check_field("to_register", 16'(want.to_register),
                                16'(m_to_register));
                    check_field("wide", 16'(want.wide), 16'(m_wide));
                    check_field("mode", 16'(want.mode), 16'(m_mode));
                    check_field("reg_field", 16'(want.reg_field), 16'(m_reg_field));
                    check_field("rm_field", 16'(want.rm_field), 16'(m_rm_field));
                    check_field("displacement", want.displacement, m_displacement);
                    check_field("immediate", want.immediate, m_immediate);
                    check_field("old_value", want.old_value, m_old_value);
                    check_field("new_value", want.new_value, m_new_value);
                    check_field("length", 16'(want.length), 16'(m_length));
                end
            end
            if (s_valid && s_ready) take_code_byte(s_code_byte);
        end
        failures <= fail_count;
        pending  <= decoded_due.size();
    end

endmodule

// ----- test/testbench.sv -----
// Top of the decoder testbench: clock, reset, code byte stream, result backpressure,
// execute_enable writes, watchdog and verdict.
// Depends on xdec_pkg, x86_16_instruction_decoder and xdec_result_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import xdec_pkg::*;

    localparam int         STALL_LIMIT  = 5000;
    localparam logic [7:0] NOP_BYTE     = 8'h90;
    localparam logic [2:0] EXEC_EN_ADDR = {CFG_EXEC_EN, 2'b00};

    // dropped byte, bad group extension, mov imm rm with reg set, mov imm to byte reg,
    // mem to acc with w=0, mov imm word with 16-bit disp, sign-extended sub, jnz, cmp ax
    localparam logic [7:0] DIRECTED_CODE [27] = '{
        8'hFF,
        8'h80, 8'h08, 8'h12,
        8'hC6, 8'hC8, 8'h55,
        8'hB0, 8'h7F,
        8'hA0, 8'h34, 8'h12,
        8'hC7, 8'h86, 8'h00, 8'h80, 8'hFF, 8'hFF,
        8'h83, 8'h6D, 8'h80, 8'h80,
        8'h75, 8'h80,
        8'h3D, 8'hFF, 8'hFF
    };
    localparam logic [7:0] EXEC_CODE [9] = '{
        8'hB8, 8'hFF, 8'hFF,
        8'hBB, 8'h00, 8'h80,
        8'hB8, 8'h01, 8'h00
    };

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [2:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_code_byte = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [1:0]         m_mnemonic;
    logic [2:0]         m_form;
    logic               m_to_register;
    logic               m_wide;
    logic [1:0]         m_mode;
    logic [2:0]         m_reg_field;
    logic [2:0]         m_rm_field;
    logic signed [15:0] m_displacement;
    logic [15:0]        m_immediate;
    logic [15:0]        m_old_value;
    logic [15:0]        m_new_value;
    logic [2:0]         m_length;

    int   failures;
    int   pending;
    int   bytes_sent   = 0;
    int   stall_cycles = 0;
    logic steady       = 1'b0;
    logic [7:0] corner_bytes [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    x86_16_instruction_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mnemonic     (m_mnemonic),
        .m_form         (m_form),
        .m_to_register  (m_to_register),
        .m_wide         (m_wide),
        .m_mode         (m_mode),
        .m_reg_field    (m_reg_field),
        .m_rm_field     (m_rm_field),
        .m_displacement (m_displacement),
        .m_immediate    (m_immediate),
        .m_old_value    (m_old_value),
        .m_new_value    (m_new_value),
        .m_length       (m_length)
    );

    xdec_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mnemonic     (m_mnemonic),
        .m_form         (m_form),
        .m_to_register  (m_to_register),
        .m_wide         (m_wide),
        .m_mode         (m_mode),
        .m_reg_field    (m_reg_field),
        .m_rm_field     (m_rm_field),
        .m_displacement (m_displacement),
        .m_immediate    (m_immediate),
        .m_old_value    (m_old_value),
        .m_new_value    (m_new_value),
        .m_length       (m_length),
        .failures       (failures),
        .pending        (pending)
    );

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic write_exec(input logic v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= EXEC_EN_ADDR;
        pwdata  <= {31'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // NOPs complete any partial instruction, then the decoder is idle for the write
    task automatic end_phase(input logic exec_value);
        repeat (6) send_byte(NOP_BYTE);
        drain();
        repeat (4) @(posedge aclk);
        write_exec(exec_value);
    endtask

    task automatic emit_instruction();
        logic [7:0] op;
        logic [7:0] modrm;
        logic [7:0] operand;
        logic       has_modrm;
        int         kind;
        int         nd;
        int         ni;
        int         tail;
        int         k;
        kind  = $urandom_range(0, 12);
        op    = 8'($urandom());
        modrm = 8'($urandom());
        unique case (kind)
            0:       op = {6'b100010, op[1:0]};
            1:       op = {7'b1100011, op[0]};
            2:       op = {4'b1011, op[3:0]};
            3:       op = {7'b1010000, op[0]};
            4:       op = {7'b1010001, op[0]};
            5:       op = {6'b100000, op[1:0]};
            6:       op = {6'b000000, op[1:0]};
            7:       op = {7'b0000010, op[0]};
            8:       op = {6'b001010, op[1:0]};
            9:       op = {7'b0010110, op[0]};
            10:      op = {6'b001110, op[1:0]};
            11:      op = {7'b0011110, op[0]};
            default: op = 8'b01110101;
        endcase
        has_modrm = kind inside {0, 1, 5, 6, 8, 10};
        nd = 0;
        if (has_modrm) begin
            unique case (modrm[7:6])
                2'd0:    nd = (modrm[2:0] == 3'd6) ? 2 : 0;
                2'd1:    nd = 1;
                2'd2:    nd = 2;
                default: nd = 0;
            endcase
        end else if (kind == 3 || kind == 4) begin
            nd = 2;
        end else if (kind == 12) begin
            nd = 1;
        end
        unique case (kind)
            1, 7, 9, 11: ni = op[0] ? 2 : 1;
            2:           ni = op[3] ? 2 : 1;
            5:           ni = (op[1:0] == 2'b01) ? 2 : 1;
            default:     ni = 0;
        endcase
        tail = int'(has_modrm) + nd + ni;
        if (tail > 0 && $urandom_range(0, 99) < 8) tail = $urandom_range(0, tail - 1);
        send_byte(op);
        for (k = 0; k < tail; k++) begin
            if (k == 0 && has_modrm)
                operand = modrm;
            else if ($urandom_range(0, 3) == 0)
                operand = corner_bytes[$urandom_range(0, 3)];
            else
                operand = 8'($urandom());
            send_byte(operand);
        end
    endtask

    task automatic random_run(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 99) < 6)
                send_byte(8'($urandom()));
            else
                emit_instruction();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_exec(1'b0);
        foreach (DIRECTED_CODE[i]) send_byte(DIRECTED_CODE[i]);
        end_phase(1'b1);
        foreach (EXEC_CODE[i]) send_byte(EXEC_CODE[i]);
        random_run(350);
        end_phase(1'b0);
        steady = 1'b1;
        random_run(200);
        steady = 1'b0;
        drain();
        random_run(150);
        end_phase(1'b1);
        random_run(400);
        drain();
        repeat (10) @(posedge aclk);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
